// ===== sv/hsfd_pkg.sv =====
// hsfd_pkg: widths, constants and shared types of the Hermite segment sampler.
// No dependencies; used by hsfd_div and hermite_segment_forward_diff_core.
`timescale 1ns / 1ps

package hsfd_pkg;

    localparam int STEPS_W    = 6;
    localparam int COORD_W    = 32;
    localparam int COEF_W     = 38;
    localparam int EXTRA_BITS = 32;
    localparam int DIV_W      = 72;
    localparam int DIV_DIGIT  = 8;
    localparam int DIV_CYCLES = DIV_W / DIV_DIGIT;
    localparam int DIV_CNT_W  = $clog2(DIV_CYCLES + 1);
    localparam int ACC_W      = 80;
    localparam int IN_TDATA_W = 4 * COORD_W;
    localparam int IN_TUSER_W = 2;
    localparam int OUT_TDATA_W = ((COORD_W + STEPS_W + 7) / 8) * 8;

    localparam logic [STEPS_W-1:0] MAX_STEPS   = 6'd63;
    localparam logic [STEPS_W-1:0] STEPS_RESET = 6'd12;
    localparam logic [COORD_W-1:0] SAT_MAX     = 32'h7fff_ffff;
    localparam logic [COORD_W-1:0] SAT_MIN     = 32'h8000_0000;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_status;

endpackage

// ===== sv/hermite_segment_forward_diff_core.sv =====
// hermite_segment_forward_diff_core: Catmull-Rom / cubic Hermite segment sampler
// with forward differencing. Depends on hsfd_pkg and hsfd_div.
//
//  channel   dir  handshake             payload (low bit first)
//  s_axis    in   tvalid/tready         tdata: p_before, p_start, p_end, p_after
//                                       tuser: has_before, has_after
//  m_axis    out  tvalid/tready/tlast   tdata: sample_value, sample_index, 2'b0
//  cfg       in   i_cfg_valid/o_cfg_ready  i_cfg_data: steps
//
// One segment runs the setup states CALC1 and CALC2, then six passes through the
// byte-serial divider (a start, the divide and a result step each), a load of the
// forward differences, steps+1 emitted samples and a return to idle before the next
// transaction is taken. The divider sets the setup length; the emit phase runs one
// sample a cycle while m_axis is not stalled.
// Reset (synchronous, active low) sets steps to 12 and empties the output stage.
// A stalled m_axis holds the sample and pauses the emit phase.
`timescale 1ns / 1ps

module hermite_segment_forward_diff_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // p_before [31:0], p_start [63:32], p_end [95:64], p_after [127:96]
    input  logic [hsfd_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // has_before [0], has_after [1]
    input  logic [hsfd_pkg::IN_TUSER_W-1:0]     s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // sample_value [31:0], sample_index [37:32], zero [39:38]
    output logic [hsfd_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    output logic                                m_axis_tlast,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [hsfd_pkg::STEPS_W-1:0]        i_cfg_data
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CALC1,
        ST_CALC2,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_INIT,
        ST_EMIT
    } t_state;

    localparam int CW = hsfd_pkg::COEF_W;
    localparam int AW = hsfd_pkg::ACC_W;
    localparam int PW = hsfd_pkg::COORD_W;
    localparam int SW = hsfd_pkg::STEPS_W;

    t_state r_state;

    logic [SW-1:0]        r_steps;
    logic [SW-1:0]        r_s;
    logic [SW-1:0]        r_idx;
    logic signed [PW-1:0] r_p0, r_p1, r_p2, r_p3;
    logic                 r_hb, r_ha;
    logic signed [CW-1:0] r_span, r_n1, r_n2;
    logic signed [CW-1:0] r_a2, r_b2, r_c2;
    logic [1:0]           r_job;
    logic [1:0]           r_pass;
    logic [hsfd_pkg::DIV_W-1:0] r_num;
    logic signed [AW-1:0] r_ka, r_kb, r_kc;
    logic signed [AW-1:0] r_q0, r_q1, r_q2, r_q3;
    logic                 r_m_valid;
    logic [PW-1:0]        r_m_value;
    logic [SW-1:0]        r_m_index;
    logic                 r_m_last;

    logic [SW-1:0]        n_s;
    logic signed [CW-1:0] n_coef;
    logic [CW-1:0]        n_mag;
    logic                 n_neg;
    logic [hsfd_pkg::DIV_W-1:0] n_dividend;
    logic [hsfd_pkg::DIV_W-1:0] n_div_in;
    logic signed [AW-1:0] n_signed_q;
    logic signed [AW-1:0] n_q3;
    logic [AW-64:0]       n_top;
    logic                 n_fits;
    logic [PW-1:0]        n_sat;
    logic                 n_div_start;

    hsfd_pkg::t_div_status      w_div_status;
    logic [hsfd_pkg::DIV_W-1:0] w_quot;

    always_comb begin
        if (r_steps == '0) begin
            n_s = SW'(1);
        end else if (r_steps > hsfd_pkg::MAX_STEPS) begin
            n_s = hsfd_pkg::MAX_STEPS;
        end else begin
            n_s = r_steps;
        end
    end

    always_comb begin
        case (r_job)
            2'd0:    n_coef = r_c2;
            2'd1:    n_coef = r_b2;
            default: n_coef = r_a2;
        endcase
        n_neg      = n_coef[CW-1];
        n_mag      = n_neg ? CW'(-n_coef) : CW'(n_coef);
        n_dividend = hsfd_pkg::DIV_W'({n_mag, {(hsfd_pkg::EXTRA_BITS-1){1'b0}}});
        n_signed_q = n_neg ? -AW'(w_quot) : AW'(w_quot);
    end

    assign n_div_start = (r_state == ST_DIV_START);
    assign n_div_in    = (r_pass == r_job + 2'd1) ? n_dividend : r_num;
    assign n_q3        = (r_ka <<< 2) + (r_ka <<< 1);

    always_comb begin
        n_top  = r_q0[AW-1:63];
        n_fits = (&n_top) | ~(|n_top);
        if (n_fits) begin
            n_sat = r_q0[63:32];
        end else begin
            n_sat = r_q0[AW-1] ? hsfd_pkg::SAT_MIN : hsfd_pkg::SAT_MAX;
        end
    end

    hsfd_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (n_div_start),
        .i_dividend (n_div_in),
        .i_divisor  (r_s),
        .o_status   (w_div_status),
        .o_quotient (w_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_steps   <= hsfd_pkg::STEPS_RESET;
            r_m_valid <= 1'b0;
            r_job     <= '0;
            r_pass    <= '0;
            r_idx     <= '0;
        end else begin
            if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (i_cfg_valid) begin
                        r_steps <= i_cfg_data;
                    end
                    if (s_axis_tvalid) begin
                        r_p0    <= s_axis_tdata[PW-1:0];
                        r_p1    <= s_axis_tdata[2*PW-1:PW];
                        r_p2    <= s_axis_tdata[3*PW-1:2*PW];
                        r_p3    <= s_axis_tdata[4*PW-1:3*PW];
                        r_hb    <= s_axis_tuser[0];
                        r_ha    <= s_axis_tuser[1];
                        r_s     <= n_s;
                        r_state <= ST_CALC1;
                    end
                end
                ST_CALC1: begin
                    r_span <= CW'(r_p2) - CW'(r_p1);
                    r_n1   <= r_hb ? CW'(r_p2) - CW'(r_p0)
                                   : (CW'(r_p2) - CW'(r_p1)) <<< 1;
                    r_n2   <= r_ha ? CW'(r_p3) - CW'(r_p1)
                                   : (CW'(r_p2) - CW'(r_p1)) <<< 1;
                    r_state <= ST_CALC2;
                end
                ST_CALC2: begin
                    r_a2    <= r_n1 + r_n2 - (r_span <<< 2);
                    r_b2    <= (r_span <<< 2) + (r_span <<< 1) - (r_n1 <<< 1) - r_n2;
                    r_c2    <= r_n1;
                    r_job   <= 2'd0;
                    r_pass  <= 2'd1;
                    r_state <= ST_DIV_START;
                end
                ST_DIV_START: begin
                    r_state <= ST_DIV_WAIT;
                end
                ST_DIV_WAIT: begin
                    if (w_div_status.done) begin
                        if (r_pass == 2'd1) begin
                            case (r_job)
                                2'd0:    r_kc <= n_signed_q;
                                2'd1:    r_kb <= n_signed_q;
                                default: r_ka <= n_signed_q;
                            endcase
                            if (r_job == 2'd2) begin
                                r_state <= ST_INIT;
                            end else begin
                                r_job   <= r_job + 1'b1;
                                r_pass  <= r_job + 2'd2;
                                r_state <= ST_DIV_START;
                            end
                        end else begin
                            r_pass  <= r_pass - 1'b1;
                            r_num   <= w_quot;
                            r_state <= ST_DIV_START;
                        end
                    end
                end
                ST_INIT: begin
                    r_q0    <= AW'({r_p1, {hsfd_pkg::EXTRA_BITS{1'b0}}})
                               | {{(AW-PW-hsfd_pkg::EXTRA_BITS){r_p1[PW-1]}},
                                  {(PW+hsfd_pkg::EXTRA_BITS){1'b0}}};
                    r_q1    <= r_ka + r_kb + r_kc;
                    r_q2    <= n_q3 + (r_kb <<< 1);
                    r_q3    <= n_q3;
                    r_idx   <= '0;
                    r_state <= ST_EMIT;
                end
                ST_EMIT: begin
                    if (!r_m_valid || m_axis_tready) begin
                        r_m_valid <= 1'b1;
                        r_m_value <= n_sat;
                        r_m_index <= r_idx;
                        r_m_last  <= (r_idx == r_s);
                        r_q0      <= r_q0 + r_q1;
                        r_q1      <= r_q1 + r_q2;
                        r_q2      <= r_q2 + r_q3;
                        r_idx     <= r_idx + 1'b1;
                        if (r_idx == r_s) begin
                            r_state <= ST_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign o_cfg_ready   = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tlast  = r_m_last;
    assign m_axis_tdata  = hsfd_pkg::OUT_TDATA_W'({r_m_index, r_m_value});

    a_div_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_status.done |-> (r_state == ST_DIV_WAIT))
        else $error("divider finished outside its wait state");

    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) |-> (r_idx <= r_s))
        else $error("sample index ran past the step count");

    a_steps_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> (r_s != '0 && r_s <= hsfd_pkg::MAX_STEPS))
        else $error("effective step count out of range");

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> (r_state == ST_CALC1))
        else $error("accepted transaction did not start setup");

    a_div_idle_on_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) |-> !w_div_status.busy)
        else $error("divider busy during emit");

endmodule

// ===== sv/hsfd_div.sv =====
// hsfd_div: unsigned divider of a wide magnitude by the 6-bit step count,
// one byte of quotient per cycle. Depends on hsfd_pkg.
`timescale 1ns / 1ps

module hsfd_div (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [hsfd_pkg::DIV_W-1:0]        i_dividend,
    input  logic [hsfd_pkg::STEPS_W-1:0]      i_divisor,
    output hsfd_pkg::t_div_status             o_status,
    output logic [hsfd_pkg::DIV_W-1:0]        o_quotient
);

    logic [hsfd_pkg::DIV_W-1:0]     r_work;
    logic [hsfd_pkg::STEPS_W-1:0]   r_div;
    logic [hsfd_pkg::STEPS_W-1:0]   r_rem;
    logic [hsfd_pkg::DIV_CNT_W-1:0] r_cnt;
    logic                           r_busy;
    logic                           r_done;

    logic [hsfd_pkg::DIV_DIGIT-1:0] n_qbyte;
    logic [hsfd_pkg::STEPS_W-1:0]   n_rem;

    always_comb begin
        logic [hsfd_pkg::STEPS_W:0]   cur;
        logic [hsfd_pkg::STEPS_W-1:0] rem;
        rem     = r_rem;
        n_qbyte = '0;
        for (int k = 0; k < hsfd_pkg::DIV_DIGIT; k++) begin
            cur = {rem, r_work[hsfd_pkg::DIV_W-1-k]};
            if (cur >= {1'b0, r_div}) begin
                n_qbyte[hsfd_pkg::DIV_DIGIT-1-k] = 1'b1;
                rem = hsfd_pkg::STEPS_W'(cur - {1'b0, r_div});
            end else begin
                rem = cur[hsfd_pkg::STEPS_W-1:0];
            end
        end
        n_rem = rem;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_work <= i_dividend;
                r_div  <= i_divisor;
                r_rem  <= '0;
                r_cnt  <= hsfd_pkg::DIV_CNT_W'(hsfd_pkg::DIV_CYCLES);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_work <= {r_work[hsfd_pkg::DIV_W-hsfd_pkg::DIV_DIGIT-1:0], n_qbyte};
                r_rem  <= n_rem;
                r_cnt  <= r_cnt - 1'b1;
                if (r_cnt == hsfd_pkg::DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_status.busy = r_busy;
    assign o_status.done = r_done;
    assign o_quotient    = r_work;

endmodule
